@@ src/ppms_pkg.sv @@
// Package for the pick-and-place mission sequencer.
// Holds the event and mode codes, field widths and register reset values.
// No dependencies; every module of the block imports it.
package ppms_pkg;

   localparam int COUNT_WIDTH = 16;

   localparam logic [3:0] GOAL_REACHED = 4'd3;

   localparam logic [15:0] LOW_MV_RESET  = 16'd10000;
   localparam logic [3:0]  RECOVER_RESET = 4'd5;

   typedef enum logic [2:0] {
      OP_GOAL    = 3'd0,
      OP_BUMP    = 3'd1,
      OP_BATTERY = 3'd2,
      OP_HOME    = 3'd3,
      OP_RETURN  = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      MODE_FIRST   = 3'd0,
      MODE_LEG     = 3'd1,
      MODE_WAIT    = 3'd2,
      MODE_HOMENAV = 3'd3,
      MODE_HOLD    = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      TARGET_HOME  = 2'd0,
      TARGET_PICK  = 2'd1,
      TARGET_PLACE = 2'd2
   } target_type;

   typedef enum logic {
      CSR_LOW_MV  = 1'b0,
      CSR_RECOVER = 1'b1
   } csr_index_type;

endpackage

@@ src/pick_place_mission_sequencer.sv @@
// Top level of the pick-and-place mission sequencer.
// Registers each event beat, updates the mission state and registers one result beat.
// Depends on ppms_pkg.
//
//   channel   direction  handshake               payload
//   req_      in         req_valid / req_stall   op, goal_status, bumper_byte, battery_mv
//   rsp_      out        rsp_valid / rsp_stall   goal_issue ... places_done
//   csr_      in         csr_write_enable        csr_index, csr_write_data
//
// Every event beat gives one result beat; an accepted beat passes the input register and then the
// result register, which drives rsp_valid. One beat can be accepted in every cycle while req_stall
// is low; the state update is a single pass of logic between the input register and the result register.
// Reset is synchronous and puts the block in the first-home mode.
// A stalled result register holds a full input register, which then stalls req_.
module pick_place_mission_sequencer
   import ppms_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [2:0]             req_op,
   input  logic [3:0]             req_goal_status,
   input  logic [7:0]             req_bumper_byte,
   input  logic [15:0]            req_battery_mv,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_goal_issue,
   output logic [1:0]             rsp_goal_target,
   output logic [2:0]             rsp_mode,
   output logic                   rsp_job,
   output logic                   rsp_old_job,
   output logic                   rsp_battery_low_flag,
   output logic [COUNT_WIDTH-1:0] rsp_places_done,
   input  logic                   csr_write_enable,
   input  logic                   csr_index,
   input  logic [15:0]            csr_write_data
);

   logic [15:0] low_mv_ff;
   logic [3:0]  recover_ff;

   logic        in_valid_ff;
   logic [2:0]  in_op_ff;
   logic [3:0]  in_status_ff;
   logic [7:0]  in_bump_ff;
   logic [15:0] in_mv_ff;

   logic        out_valid_ff;
   logic        out_issue_ff;
   logic [1:0]  out_target_ff;
   logic [2:0]  out_mode_ff;
   logic        out_job_ff;
   logic        out_old_job_ff;
   logic        out_low_ff;

   mode_type             mode_ff, mode_in;
   logic                 job_ff, job_in;
   logic                 low_ff, low_in;
   logic [3:0]           count_ff, count_in;
   logic                 force_ff, force_in;
   logic [7:0]           latch_ff, latch_in;
   logic [COUNT_WIDTH-1:0] places_ff, places_in;
   logic                 issue;
   logic [1:0]           target;

   logic advance;
   logic fire;
   logic was_override;
   logic now_override;
   logic [7:0] fin_latch;
   logic [3:0] count_inc;

   assign advance   = !out_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         low_mv_ff  <= LOW_MV_RESET;
         recover_ff <= RECOVER_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_LOW_MV:  low_mv_ff  <= csr_write_data;
            CSR_RECOVER: recover_ff <= csr_write_data[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_op_ff     <= req_op;
         in_status_ff <= req_goal_status;
         in_bump_ff   <= req_bumper_byte;
         in_mv_ff     <= req_battery_mv;
      end
   end

   // Next mission state for the beat in the input register.
   always_comb begin
      mode_in      = mode_ff;
      job_in       = job_ff;
      low_in       = low_ff;
      count_in     = count_ff;
      force_in     = force_ff;
      latch_in     = latch_ff;
      places_in    = places_ff;
      issue        = 1'b0;
      was_override = low_ff || force_ff;
      fin_latch    = (in_op_ff == OP_BUMP) ? in_bump_ff : latch_ff;
      count_inc    = count_ff + 4'd1;

      case (in_op_ff)
         OP_GOAL: begin
            if (in_status_ff == GOAL_REACHED) begin
               if (mode_ff == MODE_FIRST) begin
                  mode_in = was_override ? MODE_HOMENAV : MODE_LEG;
                  issue   = 1'b1;
               end else if (mode_ff == MODE_HOMENAV) begin
                  mode_in = MODE_HOLD;
               end
            end
         end
         OP_BUMP: latch_in = in_bump_ff;
         OP_BATTERY: begin
            if (in_mv_ff < low_mv_ff) begin
               low_in = 1'b1;
            end else if (count_inc >= recover_ff) begin
               low_in   = 1'b0;
               count_in = 4'd0;
            end else begin
               count_in = count_inc;
            end
         end
         OP_HOME:   force_in = 1'b1;
         OP_RETURN: force_in = 1'b0;
         default: ;
      endcase

      if ((in_op_ff == OP_GOAL && in_status_ff == GOAL_REACHED && mode_ff == MODE_LEG) ||
          (in_op_ff == OP_BUMP && mode_ff == MODE_WAIT)) begin
         if (fin_latch == 8'd0) begin
            mode_in = MODE_WAIT;
         end else begin
            latch_in = 8'd0;
            if (job_ff) begin
               places_in = places_ff + COUNT_WIDTH'(1);
            end
            job_in  = !job_ff;
            mode_in = MODE_LEG;
            issue   = 1'b1;
         end
      end

      now_override = low_in || force_in;
      if (in_op_ff == OP_BATTERY || in_op_ff == OP_HOME || in_op_ff == OP_RETURN) begin
         if (now_override && !was_override &&
             (mode_in == MODE_LEG || mode_in == MODE_WAIT)) begin
            mode_in = MODE_HOMENAV;
            issue   = 1'b1;
         end else if (!now_override && (mode_in == MODE_HOMENAV || mode_in == MODE_HOLD)) begin
            mode_in = MODE_LEG;
            issue   = 1'b1;
         end
      end
   end

   // Result fields derived from the next state.
   always_comb begin
      if (mode_in == MODE_LEG || mode_in == MODE_WAIT) begin
         target = job_in ? TARGET_PLACE : TARGET_PICK;
      end else begin
         target = TARGET_HOME;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_FIRST;
         job_ff    <= 1'b0;
         low_ff    <= 1'b0;
         count_ff  <= 4'd0;
         force_ff  <= 1'b0;
         latch_ff  <= 8'd0;
         places_ff <= '0;
      end else if (fire) begin
         mode_ff   <= mode_in;
         job_ff    <= job_in;
         low_ff    <= low_in;
         count_ff  <= count_in;
         force_ff  <= force_in;
         latch_ff  <= latch_in;
         places_ff <= places_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_issue_ff   <= issue;
         out_target_ff  <= target;
         out_mode_ff    <= mode_in;
         out_job_ff     <= job_in;
         out_old_job_ff <= job_ff;
         out_low_ff     <= low_in;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_goal_issue       = out_issue_ff;
   assign rsp_goal_target      = out_target_ff;
   assign rsp_mode             = out_mode_ff;
   assign rsp_job              = out_job_ff;
   assign rsp_old_job          = out_old_job_ff;
   assign rsp_battery_low_flag = out_low_ff;
   assign rsp_places_done      = places_ff;

   assert property (@(posedge clock) disable iff (reset)
      fire |=> (places_ff == $past(places_ff)) ||
               (places_ff == COUNT_WIDTH'($past(places_ff) + COUNT_WIDTH'(1))))
      else $error("place counter moved by more than one");

   assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(mode_ff) && $stable(places_ff) && $stable(job_ff))
      else $error("mission state changed without an event");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_mode == MODE_HOLD) |-> (rsp_goal_target == TARGET_HOME && !rsp_goal_issue))
      else $error("home hold reported a leg target or a new goal");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_goal_issue && rsp_goal_target == TARGET_HOME) |->
         (rsp_mode == MODE_HOMENAV))
      else $error("home goal issued outside home navigation");

   assert property (@(posedge clock) disable iff (reset)
      !out_valid_ff |-> !req_stall)
      else $error("input stalled while the result register is empty");

endmodule
